// ===== rtl/tavl_pkg.sv =====
// Shared types and constants of the tag attribute value locator.
`default_nettype none

package tavl_pkg;

  localparam int unsigned MAX_NAME_BYTES = 8;
  localparam int unsigned POSITION_BITS  = 16;

  localparam int unsigned NameW   = 64;
  localparam int unsigned LenW    = 4;
  localparam int unsigned OutW    = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_NAME_BYTES  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_NAME_LENGTH = 1'b1;

  typedef struct packed {
    logic            found;
    logic [OutW-1:0] offset;
    logic [OutW-1:0] length;
    logic            overflow;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/tag_attribute_value_locator.sv =====
// Top level of the tag attribute value locator.
// Throughput: one tag word per cycle while input ready is high.
// Latency: the result of a tag is valid in the cycle after its last word is accepted.
// Input ready drops only while a result word is held and the consumer is not ready.
// Reset is asynchronous and active low; it clears all scan state and the result valid,
// and sets the name to zero with a length of one.
`default_nettype none

module tag_attribute_value_locator #(
  parameter int unsigned MaxNameBytes = tavl_pkg::MAX_NAME_BYTES,
  parameter int unsigned PosW         = tavl_pkg::POSITION_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tavl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [tavl_pkg::NameW-1:0]   cfg_data_i,
  input  wire logic                         tag_valid_i,
  output logic                              tag_ready_o,
  input  wire logic [7:0]                   tag_byte_i,
  input  wire logic                         tag_end_i,
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output logic                              attr_found_o,
  output logic [tavl_pkg::OutW-1:0]         value_offset_o,
  output logic [tavl_pkg::OutW-1:0]         value_length_o,
  output logic                              length_overflow_o
);

  logic           step;
  logic           res_valid;
  tavl_pkg::res_t scan_res;
  tavl_pkg::res_t out_res;

  assign tag_ready_o = !res_valid || res_ready_i;
  assign step        = tag_valid_i && tag_ready_o;

  tavl_scan #(
    .MaxNameBytes(MaxNameBytes),
    .PosW        (PosW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .tag_byte_i (tag_byte_i),
    .tag_end_i  (tag_end_i),
    .res_o      (scan_res)
  );

  tavl_result_reg u_result_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step && tag_end_i),
    .res_i      (scan_res),
    .res_ready_i(res_ready_i),
    .res_valid_o(res_valid),
    .res_o      (out_res)
  );

  assign res_valid_o       = res_valid;
  assign attr_found_o      = out_res.found;
  assign value_offset_o    = out_res.offset;
  assign value_length_o    = out_res.length;
  assign length_overflow_o = out_res.overflow;

endmodule

`default_nettype wire

// ===== rtl/tavl_name_match.sv =====
// Compares the newest tag bytes against the configured attribute name.
`default_nettype none

module tavl_name_match #(
  parameter int unsigned MaxNameBytes = tavl_pkg::MAX_NAME_BYTES,
  parameter int unsigned PosW         = tavl_pkg::POSITION_BITS
) (
  input  wire logic [8*MaxNameBytes-1:0] recent_i,
  input  wire logic [MaxNameBytes:0]     hist_i,
  input  wire logic [PosW-1:0]           pos_i,
  input  wire logic [8*MaxNameBytes-1:0] name_i,
  input  wire logic [tavl_pkg::LenW-1:0] len_i,
  output logic                           hit_o
);

  logic [tavl_pkg::LenW-1:0] len_eff;
  logic [MaxNameBytes:1]     hit_k;

  assign len_eff = (len_i > tavl_pkg::LenW'(MaxNameBytes)) ?
                   tavl_pkg::LenW'(MaxNameBytes) : len_i;

  always_comb begin
    hit_k = '0;
    for (int k = 1; k <= MaxNameBytes; k++) begin
      hit_k[k] = (pos_i >= PosW'(k - 1)) && !hist_i[k];
      for (int m = 0; m < k; m++) begin
        if (recent_i[8*(k-1-m) +: 8] != name_i[8*m +: 8]) begin
          hit_k[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit_o = 1'b0;
    for (int k = 1; k <= MaxNameBytes; k++) begin
      if (len_eff == tavl_pkg::LenW'(k)) begin
        hit_o = hit_k[k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tavl_scan.sv =====
// Per-word tag scanner: configuration, byte history, parse phase and value span.
`default_nettype none

module tavl_scan #(
  parameter int unsigned MaxNameBytes = tavl_pkg::MAX_NAME_BYTES,
  parameter int unsigned PosW         = tavl_pkg::POSITION_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tavl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [tavl_pkg::NameW-1:0]     cfg_data_i,
  input  wire logic                           step_i,
  input  wire logic [7:0]                     tag_byte_i,
  input  wire logic                           tag_end_i,
  output tavl_pkg::res_t                      res_o
);

  localparam int unsigned RecW  = 8 * MaxNameBytes;
  localparam int unsigned HistW = MaxNameBytes + 1;
  localparam logic [PosW-1:0] PosLimit = {PosW{1'b1}};

  localparam logic [7:0] CaseBit  = 8'h20;
  localparam logic [7:0] ChEq     = 8'h3d;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;

  typedef enum logic [5:0] {
    PhSearch = 6'b000001,
    PhEq     = 6'b000010,
    PhQuote  = 6'b000100,
    PhBoth   = 6'b001000,
    PhValue  = 6'b010000,
    PhClosed = 6'b100000
  } phase_e;

  logic [RecW-1:0]           name_q;
  logic [tavl_pkg::LenW-1:0] len_q;
  logic [RecW-1:0]           recent_q, recent_d;
  logic [HistW-1:0]          hist_q, hist_d;
  logic [PosW-1:0]           pos_q, pos_d;
  phase_e                    phase_q, phase_d;
  logic                      single_q, single_d;
  logic [PosW-1:0]           start_q, start_d;
  logic [PosW-1:0]           flen_q, flen_d;
  logic                      ovf_q, ovf_d;

  logic       saturated;
  logic       is_letter;
  logic       is_space;
  logic       is_quote;
  logic       name_hit;
  logic       want_eq;
  logic       want_q;
  logic       na;
  logic       nb;
  logic [7:0] close_char;
  logic       found;
  logic [PosW-1:0] off_w;
  logic [PosW-1:0] len_w;

  assign saturated = (pos_q == PosLimit);
  assign pos_d     = saturated ? pos_q : pos_q + PosW'(1);
  assign ovf_d     = ovf_q | saturated;

  assign is_letter = ((tag_byte_i >= 8'h61) && (tag_byte_i <= 8'h7a)) ||
                     ((tag_byte_i >= 8'h41) && (tag_byte_i <= 8'h5a));
  assign is_space  = (tag_byte_i == ChSpace) || (tag_byte_i == ChTab) ||
                     (tag_byte_i == ChLf) || (tag_byte_i == ChCr);
  assign is_quote  = (tag_byte_i == ChDquote) || (tag_byte_i == ChSquote);

  assign recent_d = (recent_q << 8) | RecW'(tag_byte_i | CaseBit);
  assign hist_d   = (hist_q << 1) | HistW'(is_letter);

  tavl_name_match #(
    .MaxNameBytes(MaxNameBytes),
    .PosW        (PosW)
  ) u_name_match (
    .recent_i(recent_d),
    .hist_i  (hist_d),
    .pos_i   (pos_q),
    .name_i  (name_q),
    .len_i   (len_q),
    .hit_o   (name_hit)
  );

  assign close_char = single_q ? ChSquote : ChDquote;

  always_comb begin
    want_eq = 1'b0;
    want_q  = 1'b0;
    case (phase_q)
      PhEq: begin
        want_eq = 1'b1;
      end
      PhQuote: begin
        want_q = 1'b1;
      end
      PhBoth: begin
        want_eq = 1'b1;
        want_q  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign na = (want_eq && is_space) || name_hit;
  assign nb = (want_q && is_space) || (want_eq && (tag_byte_i == ChEq));

  always_comb begin
    phase_d  = phase_q;
    single_d = single_q;
    start_d  = start_q;
    flen_d   = flen_q;
    case (phase_q)
      PhValue: begin
        if (tag_byte_i == close_char) begin
          flen_d  = (pos_q >= start_q) ? pos_q - start_q : '0;
          phase_d = PhClosed;
        end
      end
      PhClosed: begin
      end
      default: begin
        if (want_q && is_quote) begin
          phase_d  = PhValue;
          single_d = (tag_byte_i == ChSquote);
          start_d  = pos_d;
        end else if (na && nb) begin
          phase_d = PhBoth;
        end else if (na) begin
          phase_d = PhEq;
        end else if (nb) begin
          phase_d = PhQuote;
        end else begin
          phase_d = PhSearch;
        end
      end
    endcase
  end

  always_comb begin
    found = 1'b0;
    len_w = '0;
    case (phase_d)
      PhValue: begin
        found = 1'b1;
        len_w = (pos_d >= start_d) ? pos_d - start_d : '0;
      end
      PhClosed: begin
        found = 1'b1;
        len_w = flen_d;
      end
      default: begin
      end
    endcase
  end

  assign off_w = found ? start_d : '0;

  generate
    if (PosW >= tavl_pkg::OutW) begin : g_trunc
      assign res_o.offset = off_w[tavl_pkg::OutW-1:0];
      assign res_o.length = len_w[tavl_pkg::OutW-1:0];
    end else begin : g_ext
      assign res_o.offset = {{(tavl_pkg::OutW-PosW){1'b0}}, off_w};
      assign res_o.length = {{(tavl_pkg::OutW-PosW){1'b0}}, len_w};
    end
  endgenerate

  assign res_o.found    = found;
  assign res_o.overflow = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_q <= '0;
      len_q  <= tavl_pkg::LenW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tavl_pkg::CFG_NAME_BYTES: begin
          name_q <= cfg_data_i[RecW-1:0];
        end
        tavl_pkg::CFG_NAME_LENGTH: begin
          len_q <= cfg_data_i[tavl_pkg::LenW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      hist_q   <= '0;
      pos_q    <= '0;
      phase_q  <= PhSearch;
      single_q <= 1'b0;
      start_q  <= '0;
      flen_q   <= '0;
      ovf_q    <= 1'b0;
    end else if (step_i) begin
      if (tag_end_i) begin
        recent_q <= '0;
        hist_q   <= '0;
        pos_q    <= '0;
        phase_q  <= PhSearch;
        single_q <= 1'b0;
        start_q  <= '0;
        flen_q   <= '0;
        ovf_q    <= 1'b0;
      end else begin
        recent_q <= recent_d;
        hist_q   <= hist_d;
        pos_q    <= pos_d;
        phase_q  <= phase_d;
        single_q <= single_d;
        start_q  <= start_d;
        flen_q   <= flen_d;
        ovf_q    <= ovf_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tavl_result_reg.sv =====
// Output register that holds one result word until the consumer takes it.
`default_nettype none

module tavl_result_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire tavl_pkg::res_t res_i,
  input  wire logic           res_ready_i,
  output logic                res_valid_o,
  output tavl_pkg::res_t      res_o
);

  logic           valid_q;
  tavl_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== dv/tavl_span_checker.sv =====
// Checker that predicts and compares the attribute value spans of the tag attribute value locator.
`timescale 1ns / 1ps

module tavl_span_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tavl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [tavl_pkg::NameW-1:0]   cfg_data_i,
  input  wire logic                         tag_valid_i,
  input  wire logic                         tag_ready_i,
  input  wire logic [7:0]                   tag_byte_i,
  input  wire logic                         tag_end_i,
  input  wire logic                         res_valid_i,
  input  wire logic                         res_ready_i,
  input  wire logic                         attr_found_i,
  input  wire logic [tavl_pkg::OutW-1:0]    value_offset_i,
  input  wire logic [tavl_pkg::OutW-1:0]    value_length_i,
  input  wire logic                         length_overflow_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_VALUE  = 3'd4;
  localparam logic [2:0] PH_CLOSED = 3'd5;

  localparam logic [tavl_pkg::OutW-1:0] POS_MAX = '1;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  logic [tavl_pkg::NameW-1:0] name_bytes;
  logic [tavl_pkg::LenW-1:0]  name_size;

  logic [63:0]               folded_bytes;
  logic [8:0]                alpha_flags;
  logic [tavl_pkg::OutW-1:0] byte_pos;
  logic [2:0]                phase;
  logic                      single_quoted;
  logic [tavl_pkg::OutW-1:0] span_start;
  logic [tavl_pkg::OutW-1:0] span_len;
  logic                      saturated;

  tavl_pkg::res_t expected_spans[$];

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic logic name_ends_at(input logic [tavl_pkg::OutW-1:0] p);
    int unsigned n;
    int unsigned pp;
    n = 32'(name_size);
    pp = 32'(p);
    if (n == 0) return 1'b0;
    if (n > tavl_pkg::MAX_NAME_BYTES) n = tavl_pkg::MAX_NAME_BYTES;
    if (pp + 1 < n) return 1'b0;
    for (int unsigned m = 0; m < n; m++) begin
      if (folded_bytes[8*(n-1-m) +: 8] != name_bytes[8*m +: 8]) return 1'b0;
    end
    return !alpha_flags[n];
  endfunction

  task automatic clear_scan();
    folded_bytes  = '0;
    alpha_flags   = '0;
    byte_pos      = '0;
    phase         = PH_SEARCH;
    single_quoted = 1'b0;
    span_start    = '0;
    span_len      = '0;
    saturated     = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    logic [tavl_pkg::OutW-1:0] p;
    logic [tavl_pkg::OutW-1:0] nxt;
    logic                      want_eq;
    logic                      want_q;
    logic                      na;
    logic                      nb;
    tavl_pkg::res_t            span;
    p = byte_pos;
    if (p == POS_MAX) begin
      saturated = 1'b1;
      nxt = POS_MAX;
    end else begin
      nxt = p + 1'b1;
    end
    byte_pos = nxt;
    folded_bytes = {folded_bytes[55:0], b | 8'h20};
    alpha_flags = {alpha_flags[7:0], is_alpha(b)};

    if (phase == PH_VALUE) begin
      if (b == (single_quoted ? CH_SQUOTE : CH_DQUOTE)) begin
        span_len = (p >= span_start) ? p - span_start : '0;
        phase = PH_CLOSED;
      end
    end else if (phase != PH_CLOSED) begin
      want_eq = (phase < PH_VALUE) && phase[0];
      want_q  = (phase < PH_VALUE) && phase[1];
      if (want_q && (b == CH_DQUOTE || b == CH_SQUOTE)) begin
        phase = PH_VALUE;
        single_quoted = (b == CH_SQUOTE);
        span_start = nxt;
      end else begin
        na = want_eq && is_blank(b);
        nb = (want_q && is_blank(b)) || (want_eq && b == CH_EQUALS);
        if (name_ends_at(p)) na = 1'b1;
        phase = {1'b0, nb, na};
      end
    end

    if (last) begin
      span = '0;
      if (phase == PH_VALUE) begin
        span.found  = 1'b1;
        span.offset = span_start;
        span.length = (nxt >= span_start) ? nxt - span_start : '0;
      end else if (phase == PH_CLOSED) begin
        span.found  = 1'b1;
        span.offset = span_start;
        span.length = span_len;
      end
      span.overflow = saturated;
      expected_spans.push_back(span);
      clear_scan();
    end
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_span();
    tavl_pkg::res_t want;
    if (expected_spans.size() == 0) begin
      $display("%0t ns: result word with nothing expected, got found %0d offset %0d length %0d",
               $time, attr_found_i, value_offset_i, value_length_i);
      fail_count_o++;
      return;
    end
    want = expected_spans.pop_front();
    compare_field("attr_found", 32'(want.found), 32'(attr_found_i));
    compare_field("value_offset", 32'(want.offset), 32'(value_offset_i));
    compare_field("value_length", 32'(want.length), 32'(value_length_i));
    compare_field("length_overflow", 32'(want.overflow), 32'(length_overflow_i));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_bytes = '0;
      name_size = 4'd1;
      clear_scan();
      expected_spans.delete();
      fail_count_o = 0;
    end else begin
      if (tag_valid_i && tag_ready_i) scan_byte(tag_byte_i, tag_end_i);
      if (cfg_we_i) begin
        if (cfg_index_i == tavl_pkg::CFG_NAME_BYTES) begin
          name_bytes = cfg_data_i;
        end else if (cfg_index_i == tavl_pkg::CFG_NAME_LENGTH) begin
          name_size = cfg_data_i[tavl_pkg::LenW-1:0];
        end
      end
      if (res_valid_i && res_ready_i) check_span();
    end
    pending_o = unsigned'(expected_spans.size());
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the testbench: clock, reset, tag word stimulus, result stalls and the verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_WORDS = 875;
  localparam int unsigned PHASE_WORDS  = 175;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [tavl_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [tavl_pkg::NameW-1:0]   cfg_data = '0;
  logic                         tag_valid = 1'b0;
  logic [7:0]                   tag_byte = '0;
  logic                         tag_end = 1'b0;
  logic                         res_ready = 1'b0;

  logic                         tag_ready;
  logic                         res_valid;
  logic                         attr_found;
  logic [tavl_pkg::OutW-1:0]    value_offset;
  logic [tavl_pkg::OutW-1:0]    value_length;
  logic                         length_overflow;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  logic        hold_req = 1'b0;

  logic [tavl_pkg::NameW-1:0] name_word = '0;
  int unsigned                name_size = 1;
  logic [7:0]                 tag_buf[$];

  always #2 clk = ~clk;

  tag_attribute_value_locator u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .tag_valid_i       (tag_valid),
    .tag_ready_o       (tag_ready),
    .tag_byte_i        (tag_byte),
    .tag_end_i         (tag_end),
    .res_valid_o       (res_valid),
    .res_ready_i       (res_ready),
    .attr_found_o      (attr_found),
    .value_offset_o    (value_offset),
    .value_length_o    (value_length),
    .length_overflow_o (length_overflow)
  );

  tavl_span_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .tag_valid_i       (tag_valid),
    .tag_ready_i       (tag_ready),
    .tag_byte_i        (tag_byte),
    .tag_end_i         (tag_end),
    .res_valid_i       (res_valid),
    .res_ready_i       (res_ready),
    .attr_found_i      (attr_found),
    .value_offset_i    (value_offset),
    .value_length_i    (value_length),
    .length_overflow_i (length_overflow),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(4, 60);
      repeat (span) begin
        @(negedge clk);
        if (hold_req) begin
          res_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0: res_ready <= 1'b1;
            1: res_ready <= 1'($urandom_range(0, 1));
            default: res_ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  function automatic logic [tavl_pkg::NameW-1:0] pack_name(input string s);
    logic [tavl_pkg::NameW-1:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < tavl_pkg::MAX_NAME_BYTES; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    tag_valid <= 1'b1;
    tag_byte <= b;
    tag_end <= last;
    do @(posedge clk); while (!tag_ready);
    words_sent++;
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(1, 8);
    @(negedge clk);
    tag_valid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    tag_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [tavl_pkg::CfgIdxW-1:0] idx,
                           input logic [tavl_pkg::NameW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_name(input logic [tavl_pkg::NameW-1:0] bytes, input int unsigned len);
    wait_drained();
    write_reg(tavl_pkg::CFG_NAME_BYTES, bytes);
    write_reg(tavl_pkg::CFG_NAME_LENGTH, tavl_pkg::NameW'(len));
    name_word = bytes;
    name_size = len;
  endtask

  task automatic send_tag();
    for (int i = 0; i < tag_buf.size(); i++) begin
      send_byte(tag_buf[i], i == tag_buf.size() - 1);
      pace_sender();
    end
  endtask

  task automatic send_text(input string s);
    tag_buf.delete();
    for (int i = 0; i < s.len(); i++) tag_buf.push_back(s[i]);
    send_tag();
  endtask

  task automatic push_separator(input logic loose);
    case ($urandom_range(0, loose ? 5 : 3))
      0: tag_buf.push_back(" ");
      1: tag_buf.push_back(8'h09);
      2: tag_buf.push_back(8'h0A);
      3: tag_buf.push_back(8'h0D);
      4: tag_buf.push_back("x");
      default: tag_buf.push_back("-");
    endcase
  endtask

  task automatic compose_tag();
    int unsigned eff;
    int unsigned cnt;
    logic [7:0]  c;
    logic [7:0]  q;
    tag_buf.delete();
    eff = (name_size > tavl_pkg::MAX_NAME_BYTES) ? tavl_pkg::MAX_NAME_BYTES : name_size;
    if ($urandom_range(0, 9) == 0) begin
      cnt = $urandom_range(1, 12);
      repeat (cnt) begin
        c = 8'($urandom_range(0, 255));
        tag_buf.push_back(c);
      end
      return;
    end
    tag_buf.push_back("<");
    repeat ($urandom_range(1, 4)) begin
      push_separator(1'b1);
      if ($urandom_range(0, 2) != 0 && eff != 0) begin
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, eff) : eff;
        for (int i = 0; i < cnt; i++) begin
          c = name_word[8*i +: 8];
          if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c ^ 8'h20;
          tag_buf.push_back(c);
        end
      end else begin
        cnt = $urandom_range(1, 5);
        repeat (cnt) begin
          c = 8'("a" + $urandom_range(0, 25));
          tag_buf.push_back(c);
        end
      end
      repeat ($urandom_range(0, 2)) push_separator(1'b0);
      if ($urandom_range(0, 7) != 0) tag_buf.push_back("=");
      repeat ($urandom_range(0, 2)) push_separator(1'b0);
      case ($urandom_range(0, 8))
        0: q = 8'($urandom_range(0, 255));
        1, 2, 3, 4: q = 8'h22;
        default: q = 8'h27;
      endcase
      tag_buf.push_back(q);
      repeat ($urandom_range(0, 6)) begin
        c = 8'($urandom_range(32, 126));
        tag_buf.push_back(c);
      end
      if ($urandom_range(0, 3) != 0) tag_buf.push_back(q);
    end
    tag_buf.push_back(">");
  endtask

  initial begin : stimulus
    logic [tavl_pkg::NameW-1:0] rand_name;
    int unsigned                rand_len;
    int unsigned                random_start;
    int unsigned                phase_stop;
    int unsigned                phase_idx;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // The name register still holds its reset value here, so nothing can match.
    tag_buf.delete();
    tag_buf.push_back(8'h00);
    tag_buf.push_back(8'hFF);
    send_tag();

    set_name(pack_name("href"), 4);
    send_text("<a href=\"x\">");
    send_text("<A HREF \t= \n'ab");
    send_text("<a xhref=\"q\">");
    send_text("<a href x=\"q\" href=\"zz\">");
    send_text("<a href=x href=''\015>");
    send_text("href=\"\"");

    set_name(pack_name("href"), 0);
    send_text("<a href=\"q\">");

    set_name(pack_name("datasets"), 15);
    send_text("<p DATASETS='v'>");

    set_name(pack_name("HREF"), 4);
    send_text("<a href=\"q\">");

    set_name('1, 8);
    tag_buf.delete();
    repeat (4) tag_buf.push_back(8'hFF);
    repeat (4) tag_buf.push_back(8'hDF);
    tag_buf.push_back("=");
    tag_buf.push_back("\"");
    tag_buf.push_back("v");
    send_tag();

    set_name(pack_name("a"), 1);
    send_text("<b a a=\"q\" a=a='r'>");

    random_start = words_sent;
    phase_idx = 0;
    while (words_sent - random_start < RANDOM_WORDS) begin
      rand_name = '0;
      for (int i = 0; i < tavl_pkg::MAX_NAME_BYTES; i++) begin
        rand_name[8*i +: 8] = ($urandom_range(0, 7) == 0) ? "-" :
                              8'("a" + $urandom_range(0, 25));
      end
      rand_len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
      set_name(rand_name, rand_len);
      if (phase_idx == 2) hold_req = 1'b1;
      phase_stop = words_sent + PHASE_WORDS;
      while (words_sent < phase_stop) begin
        compose_tag();
        send_tag();
      end
      phase_idx++;
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tavl_pkg.sv
rtl/tavl_name_match.sv
rtl/tavl_scan.sv
rtl/tavl_result_reg.sv
rtl/tag_attribute_value_locator.sv
dv/tavl_span_checker.sv
dv/testbench.sv
